@@ hdl/ecr_pkg.sv @@
// ----------------------------------------------------------------------------
// ecr_pkg
// Types and constants shared by the edge coverage recorder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ecr_pkg;

    localparam int MAP_BITS   = 12;
    localparam int COUNT_BITS = 8;

    typedef logic [MAP_BITS-1:0]   edge_t;
    typedef logic [MAP_BITS-1:0]   slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam slot_t  SLOT_NONE = '0;
    localparam slot_t  SLOT_MAX  = '1;
    localparam count_t COUNT_ONE = count_t'(1);

    typedef struct packed {
        edge_t  edge_index;
        slot_t  slot_number;
        logic   first_hit;
        count_t hit_count;
        logic   table_full;
    } result_t;

    typedef enum logic [1:0] {
        BACK_CLEAR,
        BACK_IDLE,
        BACK_LOOK,
        BACK_COUNT
    } back_state_t;

endpackage

`default_nettype wire

@@ hdl/ecr_ram.sv @@
// ----------------------------------------------------------------------------
// ecr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ecr_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 12
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/ecr_fifo.sv @@
// ----------------------------------------------------------------------------
// ecr_fifo
// Small register based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ecr_fifo #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [ADDR_BITS:0] wr_ptr_reg;
    logic [ADDR_BITS:0] wr_ptr_next;
    logic [ADDR_BITS:0] rd_ptr_reg;
    logic [ADDR_BITS:0] rd_ptr_next;
    logic               do_push;
    logic               do_pop;

    assign full  = (wr_ptr_reg[ADDR_BITS] != rd_ptr_reg[ADDR_BITS])
                && (wr_ptr_reg[ADDR_BITS-1:0] == rd_ptr_reg[ADDR_BITS-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    assign pop_data = mem_reg[rd_ptr_reg[ADDR_BITS-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[ADDR_BITS-1:0]] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ecr_front.sv @@
// ----------------------------------------------------------------------------
// ecr_front
// Accepts guard values and forms the edge index from the previous guard.
// ----------------------------------------------------------------------------
`default_nettype none

module ecr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ecr_pkg::edge_t guard_value,
    output logic               full,
    input  wire logic          clearing,
    input  wire logic          q_full,
    output logic               q_push,
    output ecr_pkg::edge_t     q_edge
);

    import ecr_pkg::*;

    edge_t last_guard_reg;
    edge_t last_guard_next;

    assign full   = q_full || clearing;
    assign q_push = push && !full;
    assign q_edge = guard_value ^ last_guard_reg;

    assign last_guard_next = q_push ? (guard_value >> 1) : last_guard_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_guard_reg <= '0;
        end
        else
        begin
            last_guard_reg <= last_guard_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ecr_back.sv @@
// ----------------------------------------------------------------------------
// ecr_back
// Looks up and assigns slots, updates hit counts, and clears the map at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ecr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire ecr_pkg::edge_t q_edge,
    output logic                q_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output ecr_pkg::result_t    res_data,
    output logic                clearing
);

    import ecr_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    slot_t       clr_addr_reg;
    slot_t       clr_addr_next;
    slot_t       slots_used_reg;
    slot_t       slots_used_next;
    edge_t       edge_reg;
    edge_t       edge_next;
    slot_t       slot_reg;
    slot_t       slot_next;

    logic        map_we;
    edge_t       map_waddr;
    slot_t       map_wdata;
    edge_t       map_raddr;
    slot_t       map_rdata;
    logic        cnt_we;
    slot_t       cnt_waddr;
    count_t      cnt_wdata;
    slot_t       cnt_raddr;
    count_t      cnt_rdata;
    slot_t       new_slot;
    count_t      count_inc;

    // edge index to slot map
    ecr_ram #(
        .WIDTH     (MAP_BITS),
        .ADDR_BITS (MAP_BITS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_addr (map_raddr),
        .rd_data (map_rdata)
    );

    // hit count per slot, first written when the slot is assigned
    ecr_ram #(
        .WIDTH     (COUNT_BITS),
        .ADDR_BITS (MAP_BITS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    assign clearing  = (state_reg == BACK_CLEAR);
    assign new_slot  = slots_used_reg + 1'b1;
    assign count_inc = cnt_rdata + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BACK_CLEAR;
            clr_addr_reg   <= '0;
            slots_used_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            slots_used_reg <= slots_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
        slot_reg <= slot_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        slots_used_next = slots_used_reg;
        edge_next       = edge_reg;
        slot_next       = slot_reg;
        q_pop           = 1'b0;
        res_push        = 1'b0;
        res_data        = '{edge_index: edge_reg, slot_number: SLOT_NONE,
                            first_hit: 1'b0, hit_count: '0, table_full: 1'b0};
        map_we          = 1'b0;
        map_waddr       = edge_reg;
        map_wdata       = SLOT_NONE;
        map_raddr       = q_edge;
        cnt_we          = 1'b0;
        cnt_waddr       = slot_reg;
        cnt_wdata       = COUNT_ONE;
        cnt_raddr       = map_rdata;

        unique case (state_reg)
            BACK_CLEAR:
            begin
                map_we        = 1'b1;
                map_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_MAX)
                begin
                    state_next = BACK_IDLE;
                end
            end
            BACK_IDLE:
            begin
                if (!q_empty && !res_full)
                begin
                    q_pop      = 1'b1;
                    edge_next  = q_edge;
                    state_next = BACK_LOOK;
                end
            end
            BACK_LOOK:
            begin
                if (map_rdata == SLOT_NONE)
                begin
                    res_push           = 1'b1;
                    res_data.first_hit = 1'b1;
                    state_next         = BACK_IDLE;
                    if (slots_used_reg != SLOT_MAX)
                    begin
                        slots_used_next      = new_slot;
                        map_we               = 1'b1;
                        map_wdata            = new_slot;
                        cnt_we               = 1'b1;
                        cnt_waddr            = new_slot;
                        res_data.slot_number = new_slot;
                        res_data.hit_count   = COUNT_ONE;
                    end
                    else
                    begin
                        res_data.table_full = 1'b1;
                    end
                end
                else
                begin
                    slot_next  = map_rdata;
                    state_next = BACK_COUNT;
                end
            end
            BACK_COUNT:
            begin
                cnt_we               = 1'b1;
                cnt_wdata            = count_inc;
                res_push             = 1'b1;
                res_data.slot_number = slot_reg;
                res_data.hit_count   = count_inc;
                state_next           = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    a_pop_then_look: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == BACK_LOOK))
        else $error("popped transaction not followed by map lookup");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_CLEAR) |-> (!q_pop && !res_push))
        else $error("transaction moved during map clear");

    a_full_only_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.table_full) |-> (slots_used_reg == SLOT_MAX))
        else $error("table full reported with free slots");

    a_slots_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BACK_CLEAR) |=> (slots_used_reg >= $past(slots_used_reg)))
        else $error("slot count went backwards");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

endmodule

`default_nettype wire

@@ hdl/edge_coverage_recorder.sv @@
// ----------------------------------------------------------------------------
// edge_coverage_recorder
// Records control flow edges from guard values into a dense coverage table.
//
// Input channel: drive guard_value and push; the transaction is taken on a
// clock edge with push high and full low. Result channel: while empty is low
// the oldest result is on edge_index, slot_number, first_hit, hit_count and
// table_full; raising pop takes it.
// A guard goes into a four-entry edge queue; the slot engine then takes
// each edge through idle and a map read for a first-hit or dropped edge,
// plus a count read and write back for a known edge, and takes the next
// edge only once back in idle, which sets the throughput.
// After reset the slot map is cleared, one entry a cycle, all 4096 entries;
// full stays high during that time. If the receiver does not pop, the
// two-entry result queue fills, the slot engine waits, the edge queue
// fills and full rises; no transaction is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_coverage_recorder (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ecr_pkg::edge_t  guard_value,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output ecr_pkg::edge_t       edge_index,
    output ecr_pkg::slot_t       slot_number,
    output logic                 first_hit,
    output ecr_pkg::count_t      hit_count,
    output logic                 table_full
);

    import ecr_pkg::*;

    logic    clearing;
    logic    eq_push;
    edge_t   eq_push_edge;
    logic    eq_full;
    logic    eq_pop;
    edge_t   eq_pop_edge;
    logic    eq_empty;
    logic    rq_push;
    result_t rq_push_data;
    logic    rq_full;
    result_t rq_pop_data;

    ecr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .guard_value (guard_value),
        .full        (full),
        .clearing    (clearing),
        .q_full      (eq_full),
        .q_push      (eq_push),
        .q_edge      (eq_push_edge)
    );

    ecr_fifo #(
        .WIDTH     (MAP_BITS),
        .ADDR_BITS (2)
    ) u_edge_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (eq_push),
        .push_data (eq_push_edge),
        .full      (eq_full),
        .pop       (eq_pop),
        .pop_data  (eq_pop_edge),
        .empty     (eq_empty)
    );

    ecr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (eq_empty),
        .q_edge   (eq_pop_edge),
        .q_pop    (eq_pop),
        .res_full (rq_full),
        .res_push (rq_push),
        .res_data (rq_push_data),
        .clearing (clearing)
    );

    ecr_fifo #(
        .WIDTH     ($bits(result_t)),
        .ADDR_BITS (1)
    ) u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rq_push),
        .push_data (rq_push_data),
        .full      (rq_full),
        .pop       (pop),
        .pop_data  (rq_pop_data),
        .empty     (empty)
    );

    assign edge_index  = rq_pop_data.edge_index;
    assign slot_number = rq_pop_data.slot_number;
    assign first_hit   = rq_pop_data.first_hit;
    assign hit_count   = rq_pop_data.hit_count;
    assign table_full  = rq_pop_data.table_full;

endmodule

`default_nettype wire
